// ===== rtl/jcws_pkg.sv =====
`timescale 1ns / 1ps

package jcws_pkg;

	// Width of the running output count. It wraps modulo two to this power.
	localparam int COUNT_WIDTH = 32;
	localparam int OUT_LEN_W = 32;

	// Depth of the queue between the classifier and the result sequencer.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL = 8'h00;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// What one input byte asks the back end to emit, in this order:
	// a released slash, the byte itself, a flushed slash, the done marker.
	typedef struct packed {
		logic       slash_pre;
		logic       keep;
		logic [7:0] data;
		logic       slash_post;
		logic       done;
	} op_t;

endpackage

// ===== rtl/jcws_fifo.sv =====
`timescale 1ns / 1ps

module jcws_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jcws_pkg::op_t   push_op,
	input  logic            pop,
	output jcws_pkg::op_t   head_op,
	output logic            full,
	output logic            empty
);

	jcws_pkg::op_t mem_q [jcws_pkg::QUEUE_DEPTH];
	logic [jcws_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [jcws_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [jcws_pkg::QPTR_W:0]   fill_q;

	assign full    = (fill_q == (jcws_pkg::QPTR_W+1)'(jcws_pkg::QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign head_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== rtl/jcws_front.sv =====
`timescale 1ns / 1ps

module jcws_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    text_byte,
	input  logic          last_byte,
	output logic          push,
	output jcws_pkg::op_t push_op
);

	logic in_str_q, line_q, block_q, star_q, slash_held_q, esc_q, prev_bs_q, ended_q;
	logic in_str_d, line_d, block_d, star_d, slash_held_d, esc_d, prev_bs_d, ended_d;
	logic esc;
	logic do_plain;
	jcws_pkg::op_t op;

	always_comb begin
		in_str_d     = in_str_q;
		line_d       = line_q;
		block_d      = block_q;
		star_d       = star_q;
		slash_held_d = slash_held_q;
		esc_d        = esc_q;
		prev_bs_d    = prev_bs_q;
		ended_d      = ended_q;
		do_plain     = 1'b0;
		op           = '0;
		op.data      = text_byte;
		esc          = !esc_q && prev_bs_q;

		if (!ended_q) begin
			esc_d     = esc;
			prev_bs_d = (text_byte == jcws_pkg::CH_BACKSLASH);

			if (text_byte != jcws_pkg::CH_NUL) begin
				if (slash_held_q) begin
					slash_held_d = 1'b0;
					if (text_byte == jcws_pkg::CH_SLASH) begin
						line_d = 1'b1;
					end else if (text_byte == jcws_pkg::CH_STAR) begin
						block_d = 1'b1;
						star_d  = 1'b0;
					end else begin
						op.slash_pre = 1'b1;
						do_plain     = 1'b1;
					end
				end else if (line_q) begin
					if (text_byte == jcws_pkg::CH_CR || text_byte == jcws_pkg::CH_LF) begin
						line_d = 1'b0;
					end
				end else if (block_q) begin
					if (text_byte == jcws_pkg::CH_SLASH && star_q) begin
						block_d = 1'b0;
						star_d  = 1'b0;
					end else begin
						star_d = (text_byte == jcws_pkg::CH_STAR);
					end
				end else begin
					do_plain = 1'b1;
				end
			end

			// A held slash is only ever outside a string, so the string flag
			// read here is the right one on both paths.
			if (do_plain) begin
				if (text_byte == jcws_pkg::CH_QUOTE && !esc) begin
					in_str_d = !in_str_q;
					op.keep  = 1'b1;
				end else if (in_str_q) begin
					op.keep = (text_byte != jcws_pkg::CH_LF) && (text_byte != jcws_pkg::CH_CR);
				end else if (text_byte == jcws_pkg::CH_SLASH) begin
					slash_held_d = 1'b1;
				end else begin
					op.keep = (text_byte != jcws_pkg::CH_SPACE) && (text_byte != jcws_pkg::CH_TAB)
						&& (text_byte != jcws_pkg::CH_LF) && (text_byte != jcws_pkg::CH_CR);
				end
			end

			if (text_byte == jcws_pkg::CH_NUL || last_byte) begin
				if (slash_held_d) begin
					slash_held_d  = 1'b0;
					op.slash_post = 1'b1;
				end
				op.done = 1'b1;
				ended_d = 1'b1;
			end
		end
	end

	assign push    = accept && (op.slash_pre || op.keep || op.slash_post || op.done);
	assign push_op = op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_str_q     <= 1'b0;
			line_q       <= 1'b0;
			block_q      <= 1'b0;
			star_q       <= 1'b0;
			slash_held_q <= 1'b0;
			esc_q        <= 1'b0;
			prev_bs_q    <= 1'b0;
			ended_q      <= 1'b0;
		end else if (accept) begin
			in_str_q     <= in_str_d;
			line_q       <= line_d;
			block_q      <= block_d;
			star_q       <= star_d;
			slash_held_q <= slash_held_d;
			esc_q        <= esc_d;
			prev_bs_q    <= prev_bs_d;
			ended_q      <= ended_d;
		end
	end

endmodule

// ===== rtl/jcws_back.sv =====
`timescale 1ns / 1ps

module jcws_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  jcws_pkg::op_t                  head_op,
	input  logic                           q_empty,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           result_kind,
	output logic [7:0]                     out_byte,
	output logic [jcws_pkg::OUT_LEN_W-1:0] out_length
);

	jcws_pkg::op_t work_q;
	jcws_pkg::op_t work_rest;
	logic work_busy;
	logic can_issue;
	logic issue;
	logic rest_empty;
	logic sel_kind;
	logic [7:0] sel_byte;
	logic [jcws_pkg::COUNT_WIDTH-1:0] count_q;
	logic [jcws_pkg::COUNT_WIDTH-1:0] count_next;
	logic out_valid_q;
	logic kind_q;
	logic [7:0] byte_q;
	logic [jcws_pkg::OUT_LEN_W-1:0] length_q;

	assign work_busy = work_q.slash_pre || work_q.keep || work_q.slash_post || work_q.done;
	assign can_issue = !out_valid_q || !out_stall;
	assign issue     = work_busy && can_issue;

	// Emit the earliest pending result and retire it from the work entry.
	always_comb begin
		work_rest = work_q;
		sel_kind  = jcws_pkg::KIND_CHAR;
		sel_byte  = jcws_pkg::CH_SLASH;
		if (work_q.slash_pre) begin
			work_rest.slash_pre = 1'b0;
		end else if (work_q.keep) begin
			work_rest.keep = 1'b0;
			sel_byte       = work_q.data;
		end else if (work_q.slash_post) begin
			work_rest.slash_post = 1'b0;
		end else begin
			work_rest.done = 1'b0;
			sel_kind       = jcws_pkg::KIND_DONE;
			sel_byte       = 8'h00;
		end
	end

	assign rest_empty = !(work_rest.slash_pre || work_rest.keep || work_rest.slash_post
		|| work_rest.done);
	assign pop = !q_empty && (!work_busy || (issue && rest_empty));
	assign count_next = (sel_kind == jcws_pkg::KIND_CHAR) ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				work_q <= head_op;
			end else if (issue) begin
				work_q <= work_rest;
			end
			if (issue) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			kind_q   <= sel_kind;
			byte_q   <= sel_byte;
			length_q <= jcws_pkg::OUT_LEN_W'(count_next);
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign out_byte    = byte_q;
	assign out_length  = length_q;

endmodule

// ===== rtl/json_comment_whitespace_stripper.sv =====
`timescale 1ns / 1ps

// Minifies JSON text streamed one byte per request: whitespace and comments outside
// strings are removed, CR and LF are dropped inside strings, and a slash is held back
// until the next byte shows whether a comment starts. A zero byte or a byte marked last
// ends the text with a done result carrying the final length; later bytes are taken
// and ignored until reset. A request is classified in the cycle it is accepted, so
// input runs at one byte per cycle unless the queue is full; results leave one per
// cycle from the output register unless out_stall holds them, and the four-entry
// queue between them absorbs bytes with two or three results: released slash, flushed
// slash, done marker. Results pass the queue, the work entry and the output register.
module json_comment_whitespace_stripper (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     text_byte,
	input  logic                           last_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           result_kind,
	output logic [7:0]                     out_byte,
	output logic [jcws_pkg::OUT_LEN_W-1:0] out_length
);

	logic accept;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	jcws_pkg::op_t push_op;
	jcws_pkg::op_t head_op;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	jcws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_byte (text_byte),
		.last_byte (last_byte),
		.push      (push),
		.push_op   (push_op)
	);

	jcws_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.full    (q_full),
		.empty   (q_empty)
	);

	jcws_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_op     (head_op),
		.q_empty     (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.out_byte    (out_byte),
		.out_length  (out_length)
	);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 335;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic                           kind;
		logic [7:0]                     ch;
		logic [jcws_pkg::OUT_LEN_W-1:0] len;
	} minified_t;

	// One directed request; the kept character is typed in where it is obvious.
	typedef struct packed {
		logic [7:0]  b;
		logic        lst;
		logic        typed;
		logic        keeps;
		logic [7:0]  ch;
		logic [31:0] len;
	} row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [7:0]                     text_byte;
	logic                           last_byte;
	logic                           out_valid;
	logic                           out_stall;
	logic                           result_kind;
	logic [7:0]                     out_byte;
	logic [jcws_pkg::OUT_LEN_W-1:0] out_length;

	json_comment_whitespace_stripper dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.out_byte(out_byte),
		.out_length(out_length)
	);

	// Predictor state.
	logic                             in_str, in_line, in_block, star_prev, slash_pending;
	logic                             esc_prev, bs_prev, finished;
	logic [jcws_pkg::COUNT_WIDTH-1:0] char_count;

	minified_t minified_q[$];
	minified_t step_chars[$];
	logic [7:0] tok[$];
	row_t       directed_rows[25];

	row_t cur_row;
	int   errors;
	int   cycles;
	int   burst_left;
	int   hold_left;
	bit   random_phase;
	bit   hold_done;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("ERROR cycle %0d: %s: got %0h, want %0h", cycles, what, got, want);
		errors++;
	endtask

	task automatic keep_char(input logic kind, input logic [7:0] ch);
		minified_t r;
		if (kind == jcws_pkg::KIND_CHAR)
			char_count = char_count + 1'b1;
		r.kind = kind;
		r.ch = ch;
		r.len = char_count[jcws_pkg::OUT_LEN_W-1:0];
		step_chars.push_back(r);
	endtask

	task automatic plain_char(input logic [7:0] b, input logic esc);
		if (b == jcws_pkg::CH_QUOTE && !esc) begin
			in_str = !in_str;
			keep_char(jcws_pkg::KIND_CHAR, b);
		end else if (in_str) begin
			if (b != jcws_pkg::CH_LF && b != jcws_pkg::CH_CR)
				keep_char(jcws_pkg::KIND_CHAR, b);
		end else if (b == jcws_pkg::CH_SLASH) begin
			slash_pending = 1'b1;
		end else if (b != jcws_pkg::CH_SPACE && b != jcws_pkg::CH_TAB
			&& b != jcws_pkg::CH_LF && b != jcws_pkg::CH_CR) begin
			keep_char(jcws_pkg::KIND_CHAR, b);
		end
	endtask

	task automatic minify_byte(input logic [7:0] b, input logic lst);
		logic esc;
		step_chars.delete();
		if (finished)
			return;
		// A byte is escaped only by a backslash that was not itself escaped.
		esc = !esc_prev && bs_prev;
		esc_prev = esc;
		bs_prev = (b == jcws_pkg::CH_BACKSLASH);
		if (b != jcws_pkg::CH_NUL) begin
			if (slash_pending) begin
				slash_pending = 1'b0;
				if (b == jcws_pkg::CH_SLASH) begin
					in_line = 1'b1;
				end else if (b == jcws_pkg::CH_STAR) begin
					in_block = 1'b1;
					star_prev = 1'b0;
				end else begin
					keep_char(jcws_pkg::KIND_CHAR, jcws_pkg::CH_SLASH);
					plain_char(b, esc);
				end
			end else if (in_line) begin
				if (b == jcws_pkg::CH_CR || b == jcws_pkg::CH_LF)
					in_line = 1'b0;
			end else if (in_block) begin
				if (b == jcws_pkg::CH_SLASH && star_prev) begin
					in_block = 1'b0;
					star_prev = 1'b0;
				end else begin
					star_prev = (b == jcws_pkg::CH_STAR);
				end
			end else begin
				plain_char(b, esc);
			end
		end
		if (b == jcws_pkg::CH_NUL || lst) begin
			if (slash_pending) begin
				slash_pending = 1'b0;
				keep_char(jcws_pkg::KIND_CHAR, jcws_pkg::CH_SLASH);
			end
			keep_char(jcws_pkg::KIND_DONE, jcws_pkg::CH_NUL);
			finished = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		minified_t got, want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				minify_byte(text_byte, last_byte);
				if (cur_row.typed) begin
					if (cur_row.keeps) begin
						want.kind = jcws_pkg::KIND_CHAR;
						want.ch = cur_row.ch;
						want.len = cur_row.len[jcws_pkg::OUT_LEN_W-1:0];
						minified_q.push_back(want);
					end
				end else begin
					foreach (step_chars[i])
						minified_q.push_back(step_chars[i]);
				end
			end
			if (out_valid && !out_stall) begin
				got.kind = result_kind;
				got.ch = out_byte;
				got.len = out_length;
				if (minified_q.size() == 0) begin
					report("result with nothing pending", 32'(got.ch), 32'd0);
				end else begin
					want = minified_q.pop_front();
					if (got.kind != want.kind)
						report("result_kind", 32'(got.kind), 32'(want.kind));
					if (got.ch != want.ch)
						report("out_byte", 32'(got.ch), 32'(want.ch));
					if (got.len != want.len)
						report("out_length", 32'(got.len), 32'(want.len));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: one long hold-off once random traffic starts, otherwise stall patterns.
	initial begin
		int mode, seg_left;
		out_stall = 1'b0;
		seg_left = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (random_phase && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 3);
					seg_left = $urandom_range(5, 40);
				end
				seg_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= 1'($urandom_range(0, 1));
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_byte(input logic [7:0] b, input logic lst);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 10);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		burst_left--;
	endtask

	function automatic logic [7:0] any_char();
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [7:0] ws_char();
		case ($urandom_range(0, 3))
			0: return jcws_pkg::CH_SPACE;
			1: return jcws_pkg::CH_TAB;
			2: return jcws_pkg::CH_LF;
			default: return jcws_pkg::CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] printable_char();
		logic [7:0] c;
		c = 8'($urandom_range(8'h20, 8'h7E));
		if (c == jcws_pkg::CH_QUOTE || c == jcws_pkg::CH_BACKSLASH)
			c = 8'h61;
		return c;
	endfunction

	// Appends one JSON-like token, mostly well formed, to tok.
	task automatic build_token();
		string lits;
		int k;
		lits = "{}[]:,-.0123456789eEtrufalsn";
		case ($urandom_range(0, 11))
			0, 1: repeat ($urandom_range(1, 4)) tok.push_back(ws_char());
			2, 3, 4: begin
				tok.push_back(jcws_pkg::CH_QUOTE);
				repeat ($urandom_range(0, 8)) begin
					k = $urandom_range(0, 5);
					if (k == 0) begin
						tok.push_back(jcws_pkg::CH_BACKSLASH);
						tok.push_back(any_char());
					end else if (k == 1) begin
						tok.push_back(any_char());
					end else begin
						tok.push_back(printable_char());
					end
				end
				tok.push_back(jcws_pkg::CH_QUOTE);
			end
			5: begin
				tok.push_back(jcws_pkg::CH_SLASH);
				tok.push_back(jcws_pkg::CH_SLASH);
				repeat ($urandom_range(0, 8)) tok.push_back(any_char());
				tok.push_back($urandom_range(0, 1) ? jcws_pkg::CH_LF : jcws_pkg::CH_CR);
			end
			6: begin
				tok.push_back(jcws_pkg::CH_SLASH);
				tok.push_back(jcws_pkg::CH_STAR);
				repeat ($urandom_range(0, 8)) begin
					k = $urandom_range(0, 3);
					if (k == 0)
						repeat ($urandom_range(1, 3)) tok.push_back(jcws_pkg::CH_STAR);
					else if (k == 1)
						tok.push_back(jcws_pkg::CH_SLASH);
					else
						tok.push_back(any_char());
				end
				repeat ($urandom_range(1, 3)) tok.push_back(jcws_pkg::CH_STAR);
				tok.push_back(jcws_pkg::CH_SLASH);
			end
			7, 8: repeat ($urandom_range(1, 5)) tok.push_back(lits[$urandom_range(0, lits.len() - 1)]);
			9: tok.push_back(any_char());
			default: begin
				tok.push_back(jcws_pkg::CH_SLASH);
				case ($urandom_range(0, 3))
					0: tok.push_back(ws_char());
					1: tok.push_back(jcws_pkg::CH_QUOTE);
					2: tok.push_back(printable_char());
					default: tok.push_back(any_char());
				endcase
			end
		endcase
	endtask

	initial begin
		int sent;
		errors = 0;
		cycles = 0;
		burst_left = 0;
		hold_left = 0;
		random_phase = 1'b0;
		hold_done = 1'b0;
		cur_row = '0;
		in_str = 1'b0;
		in_line = 1'b0;
		in_block = 1'b0;
		star_prev = 1'b0;
		slash_pending = 1'b0;
		esc_prev = 1'b0;
		bs_prev = 1'b0;
		finished = 1'b0;
		char_count = '0;
		in_valid = 1'b0;
		text_byte = 8'h00;
		last_byte = 1'b0;
		arst_n = 1'b0;

		directed_rows = '{
			'{8'h7B,                  1'b0, 1'b1, 1'b1, 8'h7B,                  32'd1},
			'{jcws_pkg::CH_SPACE,     1'b0, 1'b1, 1'b0, 8'h00,                  32'd0},
			'{jcws_pkg::CH_TAB,       1'b0, 1'b1, 1'b0, 8'h00,                  32'd0},
			'{jcws_pkg::CH_LF,        1'b0, 1'b1, 1'b0, 8'h00,                  32'd0},
			'{8'h01,                  1'b0, 1'b1, 1'b1, 8'h01,                  32'd2},
			'{8'hFF,                  1'b0, 1'b1, 1'b1, 8'hFF,                  32'd3},
			'{jcws_pkg::CH_QUOTE,     1'b0, 1'b1, 1'b1, jcws_pkg::CH_QUOTE,     32'd4},
			'{jcws_pkg::CH_LF,        1'b0, 1'b1, 1'b0, 8'h00,                  32'd0},
			'{jcws_pkg::CH_SPACE,     1'b0, 1'b1, 1'b1, jcws_pkg::CH_SPACE,     32'd5},
			'{jcws_pkg::CH_BACKSLASH, 1'b0, 1'b1, 1'b1, jcws_pkg::CH_BACKSLASH, 32'd6},
			'{jcws_pkg::CH_QUOTE,     1'b0, 1'b1, 1'b1, jcws_pkg::CH_QUOTE,     32'd7},
			'{jcws_pkg::CH_BACKSLASH, 1'b0, 1'b1, 1'b1, jcws_pkg::CH_BACKSLASH, 32'd8},
			'{jcws_pkg::CH_BACKSLASH, 1'b0, 1'b1, 1'b1, jcws_pkg::CH_BACKSLASH, 32'd9},
			'{jcws_pkg::CH_QUOTE,     1'b0, 1'b1, 1'b1, jcws_pkg::CH_QUOTE,     32'd10},
			'{jcws_pkg::CH_SLASH,     1'b0, 1'b1, 1'b0, 8'h00,                  32'd0},
			'{jcws_pkg::CH_SLASH,     1'b0, 1'b1, 1'b0, 8'h00,                  32'd0},
			'{jcws_pkg::CH_QUOTE,     1'b0, 1'b1, 1'b0, 8'h00,                  32'd0},
			'{jcws_pkg::CH_CR,        1'b0, 1'b1, 1'b0, 8'h00,                  32'd0},
			'{jcws_pkg::CH_SLASH,     1'b0, 1'b1, 1'b0, 8'h00,                  32'd0},
			'{jcws_pkg::CH_STAR,      1'b0, 1'b1, 1'b0, 8'h00,                  32'd0},
			'{jcws_pkg::CH_STAR,      1'b0, 1'b1, 1'b0, 8'h00,                  32'd0},
			'{jcws_pkg::CH_STAR,      1'b0, 1'b1, 1'b0, 8'h00,                  32'd0},
			'{jcws_pkg::CH_SLASH,     1'b0, 1'b1, 1'b0, 8'h00,                  32'd0},
			'{jcws_pkg::CH_SLASH,     1'b0, 1'b0, 1'b0, 8'h00,                  32'd0},
			'{jcws_pkg::CH_QUOTE,     1'b0, 1'b0, 1'b0, 8'h00,                  32'd0}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The second quote after a backslash pair closes the string: the pair escapes itself.
		foreach (directed_rows[i]) begin
			cur_row = directed_rows[i];
			send_byte(directed_rows[i].b, directed_rows[i].lst);
		end
		cur_row = '0;

		random_phase = 1'b1;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			build_token();
			while (tok.size() != 0) begin
				send_byte(tok.pop_front(), 1'b0);
				sent++;
			end
		end

		// Leave every string and comment so that the ending below releases a held slash.
		while (in_str || in_line || in_block || slash_pending) begin
			if (slash_pending)
				send_byte(jcws_pkg::CH_SPACE, 1'b0);
			else if (in_line)
				send_byte(jcws_pkg::CH_LF, 1'b0);
			else if (in_block)
				send_byte(star_prev ? jcws_pkg::CH_SLASH : jcws_pkg::CH_STAR, 1'b0);
			else
				send_byte(jcws_pkg::CH_QUOTE, 1'b0);
		end
		send_byte(jcws_pkg::CH_SLASH, 1'b0);
		send_byte(8'h78, 1'b1);
		// After the end everything is taken and dropped, a zero byte too.
		send_byte(jcws_pkg::CH_NUL, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(jcws_pkg::CH_SLASH, 1'b0);
		in_valid <= 1'b0;

		while (minified_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/jcws_pkg.sv
rtl/jcws_fifo.sv
rtl/jcws_front.sv
rtl/jcws_back.sv
rtl/json_comment_whitespace_stripper.sv
bench/testbench.sv
